// File: src/tli_pkg.sv
// Shared types and constants of the table linear interpolator.
package tli_pkg;

  localparam int unsigned ALT_W  = 32;
  localparam int unsigned DEN_W  = 64;
  localparam int unsigned TEM_W  = 32;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned SPAN_W = ALT_W + 1;
  localparam int unsigned PROD_W = DEN_W + SPAN_W;
  localparam int unsigned CNT_W  = 7;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_FIRST,
    ADDR_ONE,
    ADDR_LAST,
    ADDR_NEXT
  } addr_op_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ZERO,
    EMIT_PREV,
    EMIT_INTERP
  } emit_op_e;

  typedef struct packed {
    logic      latch_q;
    logic      load_wr;
    addr_op_e  addr_op;
    logic      cap_prev;
    logic      cap_cur;
    logic      div_start;
    logic      div_sel;
    logic      save_res;
    emit_op_e  emit_op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_span;
    logic found;
    logic scan_end;
    logic div_done;
  } dp_stat_t;

endpackage

// File: src/tli_div.sv
// Shift-add multiplier followed by restoring divider: floor(a * b / s).
module tli_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tli_pkg::DEN_W-1:0]    a_i,
  input  logic [tli_pkg::SPAN_W-1:0]   b_i,
  input  logic [tli_pkg::SPAN_W-1:0]   s_i,
  output logic                         done_o,
  output logic [tli_pkg::DEN_W-1:0]    quo_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV
  } phase_e;

  phase_e                        phase_q;
  logic [tli_pkg::CNT_W-1:0]     cnt_q;
  logic                          done_q;
  logic [tli_pkg::DEN_W-1:0]     a_q;
  logic [tli_pkg::SPAN_W-1:0]    b_q;
  logic [tli_pkg::SPAN_W-1:0]    s_q;
  logic [tli_pkg::PROD_W-1:0]    acc_q;
  logic [tli_pkg::SPAN_W-1:0]    rem_q;
  logic [tli_pkg::DEN_W-1:0]     quo_q;
  logic [tli_pkg::SPAN_W:0]      rem2;
  logic                          ge;
  logic [tli_pkg::PROD_W-1:0]    addend;

  assign rem2   = {rem_q, acc_q[tli_pkg::PROD_W-1]};
  assign ge     = rem2 >= {1'b0, s_q};
  assign addend = b_q[tli_pkg::SPAN_W-1] ? tli_pkg::PROD_W'(a_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            phase_q <= PH_MUL;
            cnt_q   <= tli_pkg::CNT_W'(tli_pkg::SPAN_W);
          end
        end
        PH_MUL: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == tli_pkg::CNT_W'(1)) begin
            phase_q <= PH_DIV;
            cnt_q   <= tli_pkg::CNT_W'(tli_pkg::PROD_W);
          end
        end
        PH_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == tli_pkg::CNT_W'(1)) begin
            phase_q <= PH_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          a_q   <= a_i;
          b_q   <= b_i;
          s_q   <= s_i;
          acc_q <= '0;
          rem_q <= '0;
          quo_q <= '0;
        end
      end
      PH_MUL: begin
        acc_q <= {acc_q[tli_pkg::PROD_W-2:0], 1'b0} + addend;
        b_q   <= {b_q[tli_pkg::SPAN_W-2:0], 1'b0};
      end
      PH_DIV: begin
        acc_q <= {acc_q[tli_pkg::PROD_W-2:0], 1'b0};
        rem_q <= ge ? tli_pkg::SPAN_W'(rem2 - {1'b0, s_q})
                    : rem2[tli_pkg::SPAN_W-1:0];
        quo_q <= {quo_q[tli_pkg::DEN_W-2:0], ge};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: src/tli_datapath.sv
// Table memories, scan registers, interpolation and result registers.
module tli_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tli_pkg::dp_cmd_t            cmd_i,
  output tli_pkg::dp_stat_t           stat_o,
  input  logic [tli_pkg::LEN_W-1:0]   len_i,
  input  logic [5:0]                  entry_index_i,
  input  logic signed [31:0]          entry_altitude_i,
  input  logic [63:0]                 entry_density_i,
  input  logic [31:0]                 entry_temperature_i,
  input  logic signed [31:0]          query_altitude_i,
  output logic [63:0]                 density_o,
  output logic [31:0]                 temperature_o,
  output logic                        in_range_o,
  output logic                        result_valid_o
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW  = (CW > tli_pkg::LEN_W) ? CW : tli_pkg::LEN_W;

  logic signed [31:0] alt_mem [TABLE_DEPTH];
  logic [63:0]        den_mem [TABLE_DEPTH];
  logic [31:0]        tem_mem [TABLE_DEPTH];

  logic [NW-1:0]      len_w, n, last, idx_w;
  logic [NW-1:0]      raddr_q;
  logic               wr_en;

  logic signed [31:0] alt_rd_q;
  logic [63:0]        den_rd_q;
  logic [31:0]        tem_rd_q;

  logic signed [31:0] q_q, prev_alt_q, cur_alt_q;
  logic [63:0]        prev_den_q, cur_den_q, v0_q, den_res_q;
  logic [31:0]        prev_tem_q, cur_tem_q, tem_res_q;
  logic               neg_q;

  logic [63:0]        v0, v1, diff, res, quo;
  logic [tli_pkg::SPAN_W-1:0] off, span;
  logic               div_done;

  logic               valid_q, in_range_q;
  logic [63:0]        dens_q;
  logic [31:0]        temp_q;

  assign len_w = NW'(len_i);
  assign n     = (len_w == '0) ? NW'(1) :
                 ((len_w > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : len_w);
  assign last  = n - NW'(1);
  assign idx_w = NW'(entry_index_i);
  assign wr_en = cmd_i.load_wr && (idx_w < n);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      alt_mem[idx_w[AW-1:0]] <= entry_altitude_i;
      den_mem[idx_w[AW-1:0]] <= entry_density_i;
      tem_mem[idx_w[AW-1:0]] <= entry_temperature_i;
    end
    alt_rd_q <= alt_mem[raddr_q[AW-1:0]];
    den_rd_q <= den_mem[raddr_q[AW-1:0]];
    tem_rd_q <= tem_mem[raddr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raddr_q <= '0;
    end else begin
      case (cmd_i.addr_op)
        tli_pkg::ADDR_FIRST: raddr_q <= '0;
        tli_pkg::ADDR_ONE:   raddr_q <= NW'(1);
        tli_pkg::ADDR_LAST:  raddr_q <= last;
        tli_pkg::ADDR_NEXT:  raddr_q <= raddr_q + NW'(1);
        default:             raddr_q <= raddr_q;
      endcase
    end
  end

  // Span operands: entry below is never above the query, so off >= 0 and span > 0.
  assign off  = {q_q[31], q_q} - {prev_alt_q[31], prev_alt_q};
  assign span = {cur_alt_q[31], cur_alt_q} - {prev_alt_q[31], prev_alt_q};
  assign v0   = cmd_i.div_sel ? {32'b0, prev_tem_q} : prev_den_q;
  assign v1   = cmd_i.div_sel ? {32'b0, cur_tem_q} : cur_den_q;
  assign diff = (v1 >= v0) ? (v1 - v0) : (v0 - v1);
  assign res  = neg_q ? (v0_q - quo) : (v0_q + quo);

  tli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (diff),
    .b_i     (off),
    .s_i     (span),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_q) q_q <= query_altitude_i;
    if (cmd_i.cap_prev) begin
      prev_alt_q <= alt_rd_q;
      prev_den_q <= den_rd_q;
      prev_tem_q <= tem_rd_q;
    end
    if (cmd_i.cap_cur) begin
      cur_alt_q <= alt_rd_q;
      cur_den_q <= den_rd_q;
      cur_tem_q <= tem_rd_q;
    end
    if (cmd_i.div_start) begin
      v0_q  <= v0;
      neg_q <= v1 < v0;
    end
    if (cmd_i.save_res) begin
      if (cmd_i.div_sel) tem_res_q <= res[31:0];
      else               den_res_q <= res;
    end
    case (cmd_i.emit_op)
      tli_pkg::EMIT_ZERO: begin
        dens_q     <= '0;
        temp_q     <= '0;
        in_range_q <= 1'b0;
      end
      tli_pkg::EMIT_PREV: begin
        dens_q     <= prev_den_q;
        temp_q     <= prev_tem_q;
        in_range_q <= 1'b1;
      end
      tli_pkg::EMIT_INTERP: begin
        dens_q     <= den_res_q;
        temp_q     <= tem_res_q;
        in_range_q <= 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= cmd_i.emit_op != tli_pkg::EMIT_NONE;
  end

  assign stat_o.out_span = (q_q < prev_alt_q) || (q_q > alt_rd_q);
  assign stat_o.found    = alt_rd_q > q_q;
  assign stat_o.scan_end = raddr_q == n;
  assign stat_o.div_done = div_done;

  assign density_o      = dens_q;
  assign temperature_o  = temp_q;
  assign in_range_o     = in_range_q;
  assign result_valid_o = valid_q;

endmodule

// File: src/tli_ctrl.sv
// Sequencer for loads, breakpoint scan and the two divisions of a query.
module tli_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                command_i,
  input  tli_pkg::dp_stat_t   stat_i,
  output tli_pkg::dp_cmd_t    cmd_o,
  output logic                busy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_W0,
    S_C0,
    S_WL,
    S_CL,
    S_TST,
    S_WS,
    S_CS,
    S_DEN_GO,
    S_DEN_RUN,
    S_TMP_GO,
    S_TMP_RUN,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (command_i == tli_pkg::CMD_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.latch_q = 1'b1;
            cmd_o.addr_op = tli_pkg::ADDR_FIRST;
            state_d       = S_W0;
          end
        end
      end
      S_W0: state_d = S_C0;
      S_C0: begin
        cmd_o.cap_prev = 1'b1;
        cmd_o.addr_op  = tli_pkg::ADDR_LAST;
        state_d        = S_WL;
      end
      S_WL: state_d = S_CL;
      S_CL: begin
        if (stat_i.out_span) begin
          cmd_o.emit_op = tli_pkg::EMIT_ZERO;
          state_d       = S_IDLE;
        end else begin
          cmd_o.addr_op = tli_pkg::ADDR_ONE;
          state_d       = S_TST;
        end
      end
      S_TST: begin
        if (stat_i.scan_end) begin
          cmd_o.emit_op = tli_pkg::EMIT_PREV;
          state_d       = S_IDLE;
        end else begin
          state_d = S_WS;
        end
      end
      S_WS: state_d = S_CS;
      S_CS: begin
        if (stat_i.found) begin
          cmd_o.cap_cur = 1'b1;
          state_d       = S_DEN_GO;
        end else begin
          cmd_o.cap_prev = 1'b1;
          cmd_o.addr_op  = tli_pkg::ADDR_NEXT;
          state_d        = S_TST;
        end
      end
      S_DEN_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DEN_RUN;
      end
      S_DEN_RUN: begin
        if (stat_i.div_done) begin
          cmd_o.save_res = 1'b1;
          state_d        = S_TMP_GO;
        end
      end
      S_TMP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
        state_d         = S_TMP_RUN;
      end
      S_TMP_RUN: begin
        cmd_o.div_sel = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.save_res = 1'b1;
          state_d        = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit_op = tli_pkg::EMIT_INTERP;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

// File: src/table_linear_interpolator.sv
// Top level of the table linear interpolator: APB register, controller, datapath.
//
// Usage: pulse start with the item fields while busy is low; the item is taken
// at that edge. A load item (command 0) writes one table entry in the same edge
// when entry_index is below the effective table length, and gives no result;
// busy stays low, so loads may follow back to back.
// A query item (command 1) raises busy. The controller reads entry 0 and the
// last entry for the span check, then scans entries 1 upward through one
// registered memory read port until a breakpoint above the query appears or the
// entries run out. Density and temperature then go one after the other through
// a shared unit: 33 shift-add steps, then 97 restoring divide steps. One query
// is in flight at a time.
// The result shows for one cycle with result_valid_o; the receiver cannot
// stall, so the strobe is never held. Busy drops in that same cycle.
// table_length sits at APB address 0, reset value 1; write it only when idle.
// Reset clears control state and table_length; table contents stay undefined
// until loaded, and no clearing pass runs.
module table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [5:0]         entry_index_i,
  input  logic signed [31:0] entry_altitude_i,
  input  logic [63:0]        entry_density_i,
  input  logic [31:0]        entry_temperature_i,
  input  logic signed [31:0] query_altitude_i,
  output logic [63:0]        density_o,
  output logic [31:0]        temperature_o,
  output logic               in_range_o,
  output logic               result_valid_o
);

  logic [tli_pkg::LEN_W-1:0] len_q;
  tli_pkg::dp_cmd_t          cmd;
  tli_pkg::dp_stat_t         stat;

  // Hold the length register; every address with paddr[2] low maps to it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= tli_pkg::LEN_W'(1);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      len_q <= pwdata[tli_pkg::LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'b0 : 32'(len_q);

  tli_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  tli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .len_i               (len_q),
    .entry_index_i       (entry_index_i),
    .entry_altitude_i    (entry_altitude_i),
    .entry_density_i     (entry_density_i),
    .entry_temperature_i (entry_temperature_i),
    .query_altitude_i    (query_altitude_i),
    .density_o           (density_o),
    .temperature_o       (temperature_o),
    .in_range_o          (in_range_o),
    .result_valid_o      (result_valid_o)
  );

  // Results appear only once the sequencer is back at rest.
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // An out-of-span result carries zero payload.
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !in_range_o) |-> (density_o == '0 && temperature_o == '0))
    else $error("nonzero payload out of span");

  // A load never occupies the block.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == tli_pkg::CMD_LOAD) |=> !busy)
    else $error("load raised busy");

  // A query never answers in the very next cycle.
  a_query_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == tli_pkg::CMD_QUERY) |=> !result_valid_o)
    else $error("query answered too early");

endmodule
